/* hdl/sdf_pkg.sv */
// Package for the signed-distance trilinear sampler.
// Holds the item, work and state types and the register indexes; no dependencies.
package sdf_pkg;

    typedef enum logic [2:0] {
        REG_SHIFT_X = 3'd0,
        REG_SHIFT_Y = 3'd1,
        REG_SHIFT_Z = 3'd2,
        REG_INV_X   = 3'd3,
        REG_INV_Y   = 3'd4,
        REG_INV_Z   = 3'd5,
        REG_SCALE   = 3'd6
    } reg_idx_t;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    localparam int REQ_DEPTH = 4;

    localparam logic signed [31:0] DIST_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] DIST_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic        func;
        logic [14:0] voxel_addr;
        logic [31:0] voxel_value;
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] pos_z;
    } req_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MAP,
        ST_MUL,
        ST_RD,
        ST_LX,
        ST_LXS,
        ST_LY,
        ST_LYS,
        ST_LZ,
        ST_LZS,
        ST_SC,
        ST_SCS,
        ST_OUT
    } eng_state_t;

endpackage

/* hdl/sdf_front.sv */
// Front part: queues requests, both voxel writes and queries, for the engine.
// Depends on sdf_pkg; feeds a short request queue towards the engine.
module sdf_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    output logic          full,
    input  sdf_pkg::req_t req_in,
    input  logic          deq,
    output logic          q_valid,
    output sdf_pkg::req_t q_head
);
    import sdf_pkg::*;

    localparam int AW = $clog2(REQ_DEPTH);

    req_t            mem_reg [REQ_DEPTH];
    logic [AW-1:0]   wr_reg;
    logic [AW-1:0]   rd_reg;
    logic [AW:0]     cnt_reg;
    logic            do_push;
    logic            do_pop;

    assign full    = (cnt_reg == (AW+1)'(REQ_DEPTH));
    assign q_valid = (cnt_reg != '0);
    assign q_head  = mem_reg[rd_reg];
    assign do_push = push && !full;
    assign do_pop  = deq && q_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_reg] <= req_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_reg <= (wr_reg == AW'(REQ_DEPTH - 1)) ? '0 : wr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_reg <= (rd_reg == AW'(REQ_DEPTH - 1)) ? '0 : rd_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (AW+1)'(do_push) - (AW+1)'(do_pop);
        end
    end
endmodule

/* hdl/sdf_engine.sv */
// Back part: voxel store, coordinate mapping, trilinear blend and scaling.
// Depends on sdf_pkg; one request at a time, eight serial voxel reads per inside query.
module sdf_engine #(
    parameter int DIM_X = 32,
    parameter int DIM_Y = 32,
    parameter int DIM_Z = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_valid,
    input  sdf_pkg::req_t q_head,
    output logic          deq,
    input  logic [31:0]   cfg_regs [7],
    output logic          res_valid,
    input  logic          res_taken,
    output logic [31:0]   res_distance,
    output logic          res_outside
);
    import sdf_pkg::*;

    localparam int TOTAL = DIM_X * DIM_Y * DIM_Z;
    localparam int DEPTH = 32768;

    logic [31:0]        grid_mem [DEPTH];
    eng_state_t         st_reg, st_next;
    req_t               cur_reg;
    logic signed [32:0] d_reg [3];
    logic [7:0]         lo_reg [3];
    logic [7:0]         hi_reg [3];
    logic [15:0]        t_reg [3];
    logic               out_reg;
    logic [2:0]         cnt_reg;
    logic signed [31:0] c_reg [8];
    logic signed [63:0] v_reg [4];
    logic signed [50:0] p_reg [2];
    logic signed [31:0] rd_q;
    logic               rd_oob;
    logic               rd_oob_reg;
    logic signed [31:0] rd_word;
    logic [14:0]        rd_addr;
    logic signed [63:0] sc_reg;
    logic [31:0]        dist_reg;
    logic               oflag_reg;
    logic               rv_reg;

    assign res_valid    = rv_reg;
    assign res_distance = dist_reg;
    assign res_outside  = oflag_reg;

    function automatic logic [7:0] upper(input logic [7:0] lo, input int dim);
        upper = (32'(lo) + 1 < dim) ? lo + 8'd1 : 8'(dim - 1);
    endfunction

    function automatic logic signed [63:0] floor16(input logic signed [63:0] x);
        floor16 = x >>> 16;
    endfunction

    always_comb
    begin
        logic [63:0] idx;
        idx = 64'(lo_reg[0]) + 64'(lo_reg[1]) * 64'(DIM_X)
            + 64'(lo_reg[2]) * 64'(DIM_X) * 64'(DIM_Y);
        if (cnt_reg[0]) idx = idx - 64'(lo_reg[0]) + 64'(hi_reg[0]);
        if (cnt_reg[1]) idx = idx + (64'(hi_reg[1]) - 64'(lo_reg[1])) * 64'(DIM_X);
        if (cnt_reg[2])
            idx = idx + (64'(hi_reg[2]) - 64'(lo_reg[2])) * 64'(DIM_X) * 64'(DIM_Y);
        rd_addr = 15'(idx);
        rd_oob = (idx >= 64'(DEPTH));
    end

    always_ff @(posedge clk)
    begin
        if (deq && q_head.func == FUNC_WRITE && 32'(q_head.voxel_addr) < TOTAL)
        begin
            grid_mem[q_head.voxel_addr] <= q_head.voxel_value;
        end
        rd_q <= grid_mem[rd_addr];
        rd_oob_reg <= rd_oob;
    end

    assign rd_word = rd_oob_reg ? '0 : rd_q;

    always_comb
    begin
        st_next = st_reg;
        deq = 1'b0;
        case (st_reg)
            ST_IDLE:
            begin
                if (q_valid && !rv_reg)
                begin
                    deq = 1'b1;
                    st_next = (q_head.func == FUNC_QUERY) ? ST_MAP : ST_IDLE;
                end
            end
            ST_MAP: st_next = ST_MUL;
            ST_MUL: st_next = ST_RD;
            ST_RD:
            begin
                if (out_reg)
                    st_next = ST_OUT;
                else if (cnt_reg == 3'd7)
                    st_next = ST_LX;
            end
            ST_LX:  st_next = ST_LXS;
            ST_LXS: st_next = ST_LY;
            ST_LY:  st_next = ST_LYS;
            ST_LYS: st_next = ST_LZ;
            ST_LZ:  st_next = ST_LZS;
            ST_LZS: st_next = ST_SC;
            ST_SC:  st_next = ST_SCS;
            ST_SCS: st_next = ST_OUT;
            ST_OUT: st_next = ST_IDLE;
            default: st_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= ST_IDLE;
            rv_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            st_reg <= st_next;
            if (res_taken) rv_reg <= 1'b0;
            if (st_reg == ST_OUT) rv_reg <= 1'b1;
            if (st_reg == ST_MUL || st_reg == ST_LX) cnt_reg <= '0;
            else if (st_reg == ST_RD) cnt_reg <= cnt_reg + 3'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        logic ok;
        logic [63:0] ip;
        logic [64:0] g;
        int dims [3];
        dims[0] = DIM_X;
        dims[1] = DIM_Y;
        dims[2] = DIM_Z;
        case (st_reg)
            ST_IDLE:
            begin
                cur_reg <= q_head;
            end
            ST_MAP:
            begin
                d_reg[0] <= 33'(signed'(cur_reg.pos_x)) - 33'(signed'(cfg_regs[REG_SHIFT_X]));
                d_reg[1] <= 33'(signed'(cur_reg.pos_y)) - 33'(signed'(cfg_regs[REG_SHIFT_Y]));
                d_reg[2] <= 33'(signed'(cur_reg.pos_z)) - 33'(signed'(cfg_regs[REG_SHIFT_Z]));
            end
            ST_MUL:
            begin
                ok = 1'b1;
                for (int a = 0; a < 3; a++)
                begin
                    g = 65'(d_reg[a][31:0]) * 65'(cfg_regs[REG_INV_X + a]);
                    ip = 64'(g >> 32);
                    if (d_reg[a] <= 0 || g == 0 || ip >= 64'(dims[a])) ok = 1'b0;
                    lo_reg[a] <= 8'(ip);
                    hi_reg[a] <= upper(8'(ip), dims[a]);
                    t_reg[a] <= g[31:16];
                end
                out_reg <= !ok;
            end
            ST_RD:
            begin
                if (cnt_reg != 3'd0) c_reg[cnt_reg - 3'd1] <= rd_word;
            end
            ST_LX:
            begin
                c_reg[7] <= rd_word;
            end
            ST_LXS:
            begin
                for (int i = 0; i < 4; i++) v_reg[i] <= 64'(c_reg[2*i])
                    + floor16(64'(signed'((64'(c_reg[2*i+1]) - 64'(c_reg[2*i]))
                        * 64'(signed'({1'b0, t_reg[0]})))));
            end
            ST_LY:
            begin
                p_reg[0] <= 51'((v_reg[1] - v_reg[0]) * 64'(signed'({1'b0, t_reg[1]})));
                p_reg[1] <= 51'((v_reg[3] - v_reg[2]) * 64'(signed'({1'b0, t_reg[1]})));
            end
            ST_LYS:
            begin
                v_reg[0] <= v_reg[0] + floor16(64'(p_reg[0]));
                v_reg[1] <= v_reg[2] + floor16(64'(p_reg[1]));
            end
            ST_LZ: p_reg[0] <= 51'((v_reg[1] - v_reg[0]) * 64'(signed'({1'b0, t_reg[2]})));
            ST_LZS: v_reg[0] <= v_reg[0] + floor16(64'(p_reg[0]));
            ST_SC: sc_reg <= v_reg[0] * 64'(signed'({1'b0, cfg_regs[REG_SCALE]}));
            ST_SCS:
            begin
                v_reg[0] <= floor16(sc_reg);
            end
            ST_OUT:
            begin
                oflag_reg <= out_reg;
                if (out_reg) dist_reg <= DIST_MAX;
                else if (v_reg[0] > 64'(DIST_MAX)) dist_reg <= DIST_MAX;
                else if (v_reg[0] < 64'(DIST_MIN)) dist_reg <= DIST_MIN;
                else dist_reg <= v_reg[0][31:0];
            end
            default: ;
        endcase
    end
endmodule

/* hdl/sdf_trilinear_sampler_core.sv */
// Top level of the signed-distance trilinear sampler.
// Depends on sdf_pkg, sdf_front and sdf_engine.
//
//   channel   handshake          payload
//   request   push / full        func voxel_addr voxel_value pos_x pos_y pos_z
//   result    empty / pop        distance outside
//   config    cfg_valid/ready    cfg_index cfg_data
//
// A write passes through the request queue into the voxel store. An inside query is paced
// by eight reads of the single voxel port and the serial blend; an outside query skips both.
// Reset is asynchronous; registers return to shift 0, spacing and scale 1.0.
// The request queue holds four entries and keeps taking requests while a result waits,
// but the engine starts no new request until the waiting result is popped.
module sdf_trilinear_sampler_core #(
    parameter int DIM_X = 32,
    parameter int DIM_Y = 32,
    parameter int DIM_Z = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic        func,
    input  logic [14:0] voxel_addr,
    input  logic [31:0] voxel_value,
    input  logic [31:0] pos_x,
    input  logic [31:0] pos_y,
    input  logic [31:0] pos_z,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] distance,
    output logic        outside,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import sdf_pkg::*;

    req_t        req;
    req_t        head;
    logic        q_valid;
    logic        deq;
    logic        rv;
    logic [31:0] cfg_regs_reg [7];

    assign req = '{func, voxel_addr, voxel_value, pos_x, pos_y, pos_z};
    assign cfg_ready = 1'b1;
    assign empty = !rv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 7; i++)
                cfg_regs_reg[i] <= (i >= 3) ? 32'd65536 : 32'd0;
        end
        else if (cfg_valid && cfg_index <= REG_SCALE)
        begin
            cfg_regs_reg[cfg_index] <= cfg_data;
        end
    end

    sdf_front u_front (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .req_in(req),
        .deq(deq), .q_valid(q_valid), .q_head(head)
    );

    sdf_engine #(.DIM_X(DIM_X), .DIM_Y(DIM_Y), .DIM_Z(DIM_Z)) u_engine (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_head(head), .deq(deq),
        .cfg_regs(cfg_regs_reg), .res_valid(rv), .res_taken(pop && rv),
        .res_distance(distance), .res_outside(outside)
    );
endmodule

/* hdl/sdf_checker.sv */
// Port-level checker for the sampler, bound to the top level.
// Depends only on the top level's ports.
module sdf_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        empty,
    input logic        pop,
    input logic [31:0] distance,
    input logic        outside,
    input logic        cfg_ready
);
    assert property (@(posedge clk) disable iff (!rst_n)
        !empty && outside |-> distance == 32'h7FFF_FFFF)
        else $error("outside result without maximum distance");
    assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(distance))
        else $error("waiting result changed");
    assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
        else $error("config port stalled");
endmodule

bind sdf_trilinear_sampler_core sdf_checker u_chk (
    .clk(clk), .rst_n(rst_n), .empty(empty), .pop(pop),
    .distance(distance), .outside(outside), .cfg_ready(cfg_ready)
);
